/* design/bcd_date_to_ordinal_and_weekday_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the BCD date core
// Concurrent property wrappers used by the checker file bdow_checker.
// ----------------------------------------------------------------------------
`ifndef BCD_DATE_TO_ORDINAL_AND_WEEKDAY_CORE_ASSERT_SVH
`define BCD_DATE_TO_ORDINAL_AND_WEEKDAY_CORE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define BDOW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bdow assertion failed");

// next-cycle implication, off while reset is low
`define BDOW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bdow assertion failed");

`endif

/* design/bdow_pkg.sv */
// ----------------------------------------------------------------------------
// bdow_pkg
// Types, constants and helper functions for the BCD date core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdow_pkg;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [8:0] ORDINAL_MAX   = 9'd399;
    localparam logic [8:0] WEEKDAY_BIAS  = 9'd6;
    localparam logic [4:0] MONTH_TENS    = 5'd10;
    localparam logic [4:0] MONTH_FEB     = 5'd2;
    localparam logic [4:0] MONTH_LAST    = 5'd12;

    typedef struct packed {
        logic [7:0] year_bcd;
        logic [4:0] month_code;
        logic [7:0] day_bcd;
    } bdow_date_t;

    typedef struct packed {
        logic       month_error;
        logic [2:0] weekday_number;
        logic [7:0] ordinal_low_bcd;
        logic [1:0] ordinal_hundreds;
    } bdow_result_t;

    function automatic logic [7:0] bcd8_value(input logic [7:0] v);
        return 8'({4'b0, v[7:4]}) * 8'd10 + 8'({4'b0, v[3:0]});
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] month_offset(input logic [3:0] idx);
        logic [2:0] o;
        unique case (idx)
            4'd0:    o = 3'd0;
            4'd1:    o = 3'd3;
            4'd2:    o = 3'd3;
            4'd3:    o = 3'd6;
            4'd4:    o = 3'd1;
            4'd5:    o = 3'd4;
            4'd6:    o = 3'd6;
            4'd7:    o = 3'd2;
            4'd8:    o = 3'd5;
            4'd9:    o = 3'd0;
            4'd10:   o = 3'd3;
            4'd11:   o = 3'd5;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

    // octal digits fold since 8 mod 7 is 1
    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
    endfunction

endpackage

/* design/bcd_date_to_ordinal_and_weekday_core.sv */
// Path: an accepted date is registered in the input stage, then its decode in the output stage.
// Throughput: one item per cycle if m_tready is high; the decode is a single combinational pass.
// m_tready reaches s_tready combinationally through the two-stage valid chain.
// Reset: synchronous, active-low aresetn clears both stage valid flags;
// the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
// bcd_date_to_ordinal_and_weekday_core
// Stream wrapper: registers a BCD date, decodes it and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcd_date_to_ordinal_and_weekday_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] day_bcd, [12:8] month_code, [20:13] year_bcd, [23:21] zero
    input  logic [bdow_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] ordinal_hundreds, [9:2] ordinal_low_bcd, [12:10] weekday_number,
    // [15:13] zero
    output logic [bdow_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] month_error
    output logic                           m_tuser
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    bdow_pkg::bdow_date_t   in_date_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    bdow_pkg::bdow_result_t out_result_reg;
    bdow_pkg::bdow_result_t calc_result;
    logic                   s_fire;
    logic                   out_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign s_fire   = s_tvalid && s_tready;

    bdow_calc u_calc (
        .date   (in_date_reg),
        .result (calc_result)
    );

    always_comb begin
        in_valid_next  = s_fire ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_date_reg <= s_tdata[$bits(bdow_pkg::bdow_date_t)-1:0];
        end
        if (out_load) begin
            out_result_reg <= calc_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.weekday_number,
                       out_result_reg.ordinal_low_bcd, out_result_reg.ordinal_hundreds};
    assign m_tuser  = out_result_reg.month_error;

endmodule

/* design/bdow_calc.sv */
// ----------------------------------------------------------------------------
// bdow_calc
// Combinational date decode: ordinal day in hundreds plus BCD, weekday and month error flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdow_calc (
    input  bdow_pkg::bdow_date_t   date,
    output bdow_pkg::bdow_result_t result
);

    logic [7:0]  day;
    logic [7:0]  year;
    logic [4:0]  month;
    logic [3:0]  idx;
    logic        bad_month;
    logic        leap;
    logic [8:0]  ordinal_raw;
    logic [8:0]  ordinal;
    logic [8:0]  wsum;
    logic [2:0]  wrem;
    logic [1:0]  hundreds;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  units;

    always_comb begin
        day       = bdow_pkg::bcd8_value(date.day_bcd);
        year      = bdow_pkg::bcd8_value(date.year_bcd);
        month     = 5'(date.month_code[3:0])
                  + (date.month_code[4] ? bdow_pkg::MONTH_TENS : 5'd0);
        bad_month = (month == 5'd0) || (month > bdow_pkg::MONTH_LAST);
        idx       = 4'(month - 5'd1);
        leap      = (year[1:0] == 2'b00);

        ordinal_raw = 9'(day) + bdow_pkg::days_before_month(idx)
                    + 9'(leap && (month > bdow_pkg::MONTH_FEB));
        ordinal     = (ordinal_raw > bdow_pkg::ORDINAL_MAX) ?
                      bdow_pkg::ORDINAL_MAX : ordinal_raw;

        wsum = bdow_pkg::WEEKDAY_BIAS + 9'(day) + 9'(year) + 9'(year[7:2])
             + 9'(bdow_pkg::month_offset(idx))
             - 9'(leap && (month <= bdow_pkg::MONTH_FEB));
        wrem = bdow_pkg::mod7(wsum - 9'd1);

        priority if (ordinal >= 9'd300) begin
            hundreds = 2'd3;
            rem      = 7'(ordinal - 9'd300);
        end else if (ordinal >= 9'd200) begin
            hundreds = 2'd2;
            rem      = 7'(ordinal - 9'd200);
        end else if (ordinal >= 9'd100) begin
            hundreds = 2'd1;
            rem      = 7'(ordinal - 9'd100);
        end else begin
            hundreds = 2'd0;
            rem      = 7'(ordinal);
        end

        // divide by ten as a multiply by 205/2048, exact for every 7-bit rem
        tens_prod = 15'(rem) * 15'd205;
        tens      = tens_prod[14:11];
        units     = 4'(rem - 7'(tens) * 7'd10);

        if (bad_month) begin
            result = '0;
            result.month_error = 1'b1;
        end else begin
            result.month_error      = 1'b0;
            result.weekday_number   = wrem + 3'd1;
            result.ordinal_low_bcd  = {tens, units};
            result.ordinal_hundreds = hundreds;
        end
    end

endmodule

/* design/bdow_checker.sv */
// ----------------------------------------------------------------------------
// bdow_checker
// Port-level checks for the BCD date core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bcd_date_to_ordinal_and_weekday_core_assert.svh"

module bdow_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [bdow_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bdow_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    logic                         in_stall;
    logic                         out_stall;
    logic [bdow_pkg::M_TDATA_W:0] m_word;
    logic                         good_fields;

    assign in_stall    = s_tvalid && !s_tready;
    assign out_stall   = m_tvalid && !m_tready;
    assign m_word      = {m_tuser, m_tdata};
    assign good_fields = (m_tdata[12:10] != 3'd0) && (m_tdata[9:6] <= 4'd9)
                       && (m_tdata[5:2] <= 4'd9);

    `BDOW_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_stall, s_tvalid && $stable(s_tdata))
    `BDOW_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_word))
    `BDOW_ASSERT_SAME(a_error_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `BDOW_ASSERT_SAME(a_good_result, aclk, aresetn, m_tvalid && !m_tuser, good_fields)
    `BDOW_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid)

endmodule

bind bcd_date_to_ordinal_and_weekday_core bdow_checker u_bdow_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression for the BCD date core. Directed dates cover leap years, day
// zero, bad month codes, non-decimal digits and ordinal saturation. About
// 1200 random dates follow, mostly BCD dates with month 1 to 12 and day 1
// to 31, plus random bit noise. Random gaps and stalls hit both channels,
// except for one calm stretch. Every result is checked against a local
// day-of-year and weekday calculation, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RANDOM_ITEMS  = 1200;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned CALM_FIRST    = 1500;
    localparam int unsigned CALM_LAST     = 2600;
    localparam int unsigned IDLE_PCT      = 32;
    localparam int unsigned VALID_PCT     = 80;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned MAX_ORDINAL   = 399;

    typedef struct {
        bdow_pkg::bdow_date_t date;
        bit                   wait_drain;
    } pending_date_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bdow_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bdow_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;

    pending_date_t          pending_dates[$];
    bdow_pkg::bdow_result_t expected_days[$];
    bdow_pkg::bdow_result_t want;
    int unsigned            cycle_count = 0;
    int unsigned            fail_count  = 0;
    logic                   s_fire      = 1'b0;

    bcd_date_to_ordinal_and_weekday_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned bcd_to_int(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic int unsigned days_before(input int unsigned month);
        case (month)
            1:       return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            default: return 334;
        endcase
    endfunction

    function automatic int unsigned month_shift(input int unsigned month);
        case (month)
            1, 10:     return 0;
            5:         return 1;
            8:         return 2;
            2, 3, 11:  return 3;
            6:         return 4;
            9, 12:     return 5;
            default:   return 6;
        endcase
    endfunction

    function automatic bdow_pkg::bdow_result_t predict_ordinal_weekday(
        input bdow_pkg::bdow_date_t d);
        bdow_pkg::bdow_result_t r;
        int unsigned            day;
        int unsigned            month;
        int unsigned            year;
        int unsigned            ordinal;
        int unsigned            weekday;
        r     = '0;
        day   = bcd_to_int(d.day_bcd);
        month = int'(d.month_code[3:0]) + (d.month_code[4] ? 10 : 0);
        year  = bcd_to_int(d.year_bcd);
        if (month < 1 || month > 12) begin
            r.month_error = 1'b1;
            return r;
        end
        ordinal = day + days_before(month);
        weekday = 6 + day + year + year / 4 + month_shift(month);
        if (year % 4 == 0) begin
            if (month > 2) begin
                ordinal++;
            end else begin
                weekday--;
            end
        end
        if (ordinal > MAX_ORDINAL) begin
            ordinal = MAX_ORDINAL;
        end
        weekday = (weekday - 1) % 7 + 1;
        r.ordinal_hundreds = 2'(ordinal / 100);
        r.ordinal_low_bcd  = {4'((ordinal % 100) / 10), 4'(ordinal % 10)};
        r.weekday_number   = 3'(weekday);
        return r;
    endfunction

    function automatic bdow_pkg::bdow_date_t random_calendar_date();
        bdow_pkg::bdow_date_t d;
        int unsigned          month;
        int unsigned          day;
        int unsigned          year;
        month        = $urandom_range(12, 1);
        day          = $urandom_range(31, 1);
        year         = $urandom_range(99, 0);
        d.month_code = (month >= 10) ? {1'b1, 4'(month - 10)} : 5'(month);
        d.day_bcd    = {4'(day / 10), 4'(day % 10)};
        d.year_bcd   = {4'(year / 10), 4'(year % 10)};
        return d;
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(99, 0) < IDLE_PCT;
    endfunction

    task automatic push_date(input logic [7:0] day, input logic [4:0] month,
                             input logic [7:0] year, input bit wait_drain);
        pending_date_t it;
        it.date.day_bcd    = day;
        it.date.month_code = month;
        it.date.year_bcd   = year;
        it.wait_drain      = wait_drain;
        pending_dates.push_back(it);
    endtask

    // drive both channels on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_fire) begin
                if (pending_dates.size() != 0 && !idle_now() &&
                    (!pending_dates[0].wait_drain || expected_days.size() == 0)) begin
                    s_tdata  <= {3'b000, pending_dates[0].date};
                    s_tvalid <= 1'b1;
                    void'(pending_dates.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !idle_now();
        end
    end

    // check results first, then record the newly accepted date
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        s_fire      <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_days.size() == 0) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
                    end
                    fail_count++;
                end else begin
                    want = expected_days.pop_front();
                    if (m_tdata[1:0] !== want.ordinal_hundreds ||
                        m_tdata[9:2] !== want.ordinal_low_bcd ||
                        m_tdata[12:10] !== want.weekday_number ||
                        m_tdata[15:13] !== 3'b000 ||
                        m_tuser !== want.month_error) begin
                        if (fail_count < REPORT_LIMIT) begin
                            $display({"mismatch: hundreds %0d/%0d low %h/%h",
                                      " wday %0d/%0d err %b/%b pad %b"},
                                     want.ordinal_hundreds, m_tdata[1:0],
                                     want.ordinal_low_bcd, m_tdata[9:2],
                                     want.weekday_number, m_tdata[12:10],
                                     want.month_error, m_tuser, m_tdata[15:13]);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_days.push_back(
                    predict_ordinal_weekday(bdow_pkg::bdow_date_t'(s_tdata[20:0])));
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bcd_date_to_ordinal_and_weekday_core regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned          n;
        bdow_pkg::bdow_date_t d;
        push_date(8'h01, 5'h01, 8'h00, 1'b0);
        push_date(8'h29, 5'h02, 8'h24, 1'b0);
        push_date(8'h01, 5'h03, 8'h24, 1'b0);
        push_date(8'h28, 5'h02, 8'h01, 1'b0);
        push_date(8'h31, 5'h12, 8'h99, 1'b0);
        push_date(8'h31, 5'h12, 8'h00, 1'b0);
        push_date(8'h00, 5'h01, 8'h01, 1'b0);
        push_date(8'h00, 5'h03, 8'h00, 1'b0);
        push_date(8'hFF, 5'h12, 8'hFF, 1'b0);
        push_date(8'h99, 5'h1F, 8'h50, 1'b0);
        push_date(8'h15, 5'h00, 8'h20, 1'b0);
        push_date(8'h15, 5'h0D, 8'h20, 1'b0);
        push_date(8'h15, 5'h0F, 8'h20, 1'b0);
        push_date(8'h15, 5'h1A, 8'h20, 1'b0);
        push_date(8'h10, 5'h10, 8'h37, 1'b0);
        push_date(8'h11, 5'h11, 8'h38, 1'b0);
        push_date(8'h25, 5'h12, 8'h39, 1'b0);
        push_date(8'h9A, 5'h07, 8'hAF, 1'b0);
        push_date(8'h14, 5'h02, 8'hA0, 1'b0);
        push_date(8'h20, 5'h05, 8'hF0, 1'b0);
        push_date(8'h15, 5'h06, 8'h50, 1'b0);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99, 0) < VALID_PCT) begin
                d = random_calendar_date();
            end else begin
                d = 21'($urandom);
            end
            push_date(d.day_bcd, d.month_code, d.year_bcd,
                      n == 0 || n == RANDOM_ITEMS / 2);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_dates.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (expected_days.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_days.size() == 0) begin
            $display("bcd_date_to_ordinal_and_weekday_core regression: pass");
        end else begin
            $display("bcd_date_to_ordinal_and_weekday_core regression: fail");
        end
        $finish;
    end

endmodule
